// ===== rtl/position_setpoint_slew_limiter_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Position setpoint slew limiter assertion macros
// Concurrent assertion shorthands shared by the checker of this block.
// ----------------------------------------------------------------------------
`ifndef POSITION_SETPOINT_SLEW_LIMITER_UNIT_ASSERT_SVH
`define POSITION_SETPOINT_SLEW_LIMITER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PSLU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("slew limiter check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PSLU_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("slew limiter check failed");

`endif

// ===== rtl/pslu_pkg.sv =====
// ----------------------------------------------------------------------------
// Position setpoint slew limiter package
// Shared widths, reset values, codes and bundled signal types.
// ----------------------------------------------------------------------------
package pslu_pkg;

    localparam int ANGLE_WIDTH_DEF = 16;
    localparam int TIMER_WIDTH_DEF = 16;
    localparam int FULL_TURN_DEF   = 23040;

    localparam int OPERATION_W     = 2;
    localparam int ANGLE_W         = 16;
    localparam int COMMAND_W       = 2;
    localparam int COMMAND_ANGLE_W = 15;
    localparam int DRIVE_W         = 8;
    localparam int STEP_INTERVAL_W = 16;
    localparam int MAX_STEP_W      = 15;
    localparam int CFG_INDEX_W     = 2;
    localparam int CFG_DATA_W      = 16;

    localparam logic [STEP_INTERVAL_W-1:0] STEP_INTERVAL_RST = 16'd10;
    localparam logic [MAX_STEP_W-1:0]      MAX_STEP_RST      = 15'd640;
    localparam logic [DRIVE_W-1:0]         DRIVE_ID_RST      = 8'd0;

    localparam logic [CFG_INDEX_W-1:0] CFG_STEP_INTERVAL = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_STEP      = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_DRIVE_ID      = 2'd2;

    typedef enum logic [OPERATION_W-1:0] {
        OP_TICK       = 2'd0,
        OP_SET_TARGET = 2'd1,
        OP_CALIBRATE  = 2'd2
    } t_operation;

    typedef enum logic [COMMAND_W-1:0] {
        CMD_NONE         = 2'd0,
        CMD_SET_POSITION = 2'd1,
        CMD_KEEPALIVE    = 2'd2
    } t_command;

    typedef struct packed {
        logic [STEP_INTERVAL_W-1:0] step_interval;
        logic [MAX_STEP_W-1:0]      max_step;
        logic [DRIVE_W-1:0]         drive_id;
    } t_cfg;

    typedef struct packed {
        t_command             command;
        logic [DRIVE_W-1:0]   drive;
        logic                 in_position;
        logic                 error;
    } t_ctrl;

endpackage

// ===== rtl/pslu_core.sv =====
// ----------------------------------------------------------------------------
// Slew limiter update stage
// Holds the angle state and interval timer, applies one beat per cycle while
// the next stage is ready, and registers the command fields with the unwrapped command angle.
// ----------------------------------------------------------------------------
module pslu_core import pslu_pkg::*; #(
    parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF,
    parameter int TIMER_WIDTH = TIMER_WIDTH_DEF,
    parameter int FULL_TURN   = FULL_TURN_DEF,
    localparam int TGT_W      = $clog2(FULL_TURN),
    localparam int PW         = (ANGLE_WIDTH > TGT_W) ? ANGLE_WIDTH : TGT_W + 1
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [OPERATION_W-1:0]     i_operation,
    input  logic signed [ANGLE_W-1:0]  i_angle,
    input  logic signed [ANGLE_W-1:0]  i_measured_angle,
    input  t_cfg                       i_cfg,
    output logic                       o_valid,
    input  logic                       i_ready,
    output t_ctrl                      o_ctrl,
    output logic signed [PW:0]         o_sum
);

    localparam int BW    = (PW > ANGLE_W + 1) ? PW : ANGLE_W + 1;
    localparam int DW    = BW + 2;
    localparam int CNT_W = (TIMER_WIDTH > STEP_INTERVAL_W) ? TIMER_WIDTH : STEP_INTERVAL_W;
    localparam logic signed [DW-1:0] A_MAX = DW'((longint'(1) << (ANGLE_WIDTH - 1)) - 1);
    localparam logic signed [DW-1:0] A_MIN = -A_MAX - DW'(1);
    localparam logic signed [DW-1:0] FT    = DW'(FULL_TURN);
    localparam logic [TIMER_WIDTH-1:0] T_MAX = {TIMER_WIDTH{1'b1}};

    logic                          r_valid;
    logic signed [PW-1:0]          r_present;
    logic [TGT_W-1:0]              r_target;
    logic signed [ANGLE_WIDTH-1:0] r_offset;
    logic                          r_reached;
    logic [TIMER_WIDTH-1:0]        r_tick;
    t_ctrl                         r_ctrl;
    logic signed [PW:0]            r_sum;

    logic signed [PW-1:0]          n_present;
    logic [TGT_W-1:0]              n_target;
    logic signed [ANGLE_WIDTH-1:0] n_offset;
    logic                          n_reached;
    logic [TIMER_WIDTH-1:0]        n_tick;
    t_ctrl                         n_ctrl;
    logic signed [PW:0]            n_sum;

    logic                   accept;
    logic [TIMER_WIDTH-1:0] tick_inc;
    logic                   tick_hit;
    logic signed [DW-1:0]   a_ext;
    logic signed [DW-1:0]   m_ext;
    logic signed [DW-1:0]   pres_ext;
    logic signed [DW-1:0]   tgt_ext;
    logic signed [DW-1:0]   ms_ext;
    logic signed [DW-1:0]   diff;
    logic                   tgt_ok;
    t_command               cmd;
    logic                   err;

    function automatic logic signed [ANGLE_WIDTH-1:0] f_sat(input logic signed [DW-1:0] v);
        if (v > A_MAX) begin
            f_sat = A_MAX[ANGLE_WIDTH-1:0];
        end else if (v < A_MIN) begin
            f_sat = A_MIN[ANGLE_WIDTH-1:0];
        end else begin
            f_sat = v[ANGLE_WIDTH-1:0];
        end
    endfunction

    assign o_in_ready = !r_valid || i_ready;
    assign accept     = i_in_valid && o_in_ready;

    assign tick_inc = (r_tick == T_MAX) ? r_tick : r_tick + TIMER_WIDTH'(1);
    assign tick_hit = CNT_W'(tick_inc) >= CNT_W'(i_cfg.step_interval);
    assign a_ext    = DW'(i_angle);
    assign m_ext    = DW'(i_measured_angle);
    assign pres_ext = DW'(r_present);
    assign tgt_ext  = DW'($signed({1'b0, r_target}));
    assign ms_ext   = DW'($signed({1'b0, i_cfg.max_step}));
    assign diff     = tgt_ext - pres_ext;
    assign tgt_ok   = (a_ext >= DW'(0)) && (a_ext < FT);

    always_comb begin
        n_present = r_present;
        n_target  = r_target;
        n_offset  = r_offset;
        n_reached = r_reached;
        n_tick    = r_tick;
        cmd       = CMD_NONE;
        err       = 1'b0;
        unique case (t_operation'(i_operation))
            OP_TICK: begin
                n_tick = tick_inc;
                if (tick_hit) begin
                    n_tick = '0;
                    if (r_reached) begin
                        cmd = CMD_KEEPALIVE;
                    end else begin
                        cmd = CMD_SET_POSITION;
                        if (diff == DW'(0)) begin
                            n_reached = 1'b1;
                        end else if (diff > ms_ext) begin
                            n_present = PW'(f_sat(pres_ext + ms_ext));
                        end else if (diff < -ms_ext) begin
                            n_present = PW'(f_sat(pres_ext - ms_ext));
                        end else begin
                            n_present = PW'($signed({1'b0, r_target}));
                        end
                    end
                end
            end
            OP_SET_TARGET: begin
                if (tgt_ok) begin
                    n_target  = a_ext[TGT_W-1:0];
                    n_reached = 1'b0;
                end else begin
                    err = 1'b1;
                end
            end
            OP_CALIBRATE: begin
                n_offset  = f_sat(m_ext - a_ext);
                n_present = PW'(f_sat(a_ext));
            end
            default: begin
            end
        endcase
        n_sum              = (PW + 1)'(n_present) + (PW + 1)'(n_offset);
        n_ctrl.command     = cmd;
        n_ctrl.drive       = (cmd != CMD_NONE) ? i_cfg.drive_id : '0;
        n_ctrl.in_position = n_reached;
        n_ctrl.error       = err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_present <= '0;
            r_target  <= '0;
            r_offset  <= '0;
            r_reached <= 1'b1;
            r_tick    <= '0;
        end else begin
            if (o_in_ready) begin
                r_valid <= i_in_valid;
            end
            if (accept) begin
                r_present <= n_present;
                r_target  <= n_target;
                r_offset  <= n_offset;
                r_reached <= n_reached;
                r_tick    <= n_tick;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ctrl <= n_ctrl;
            r_sum  <= n_sum;
        end
    end

    assign o_valid = r_valid;
    assign o_ctrl  = r_ctrl;
    assign o_sum   = r_sum;

endmodule

// ===== rtl/pslu_wrap.sv =====
// ----------------------------------------------------------------------------
// Slew limiter angle wrap pipeline
// Reduces the signed command angle modulo one full turn: bias to a positive
// value, reciprocal multiply for the quotient, multiply back and subtract,
// then one final correction into the output register.
// ----------------------------------------------------------------------------
module pslu_wrap import pslu_pkg::*; #(
    parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF,
    parameter int FULL_TURN   = FULL_TURN_DEF,
    localparam int TGT_W      = $clog2(FULL_TURN),
    localparam int PW         = (ANGLE_WIDTH > TGT_W) ? ANGLE_WIDTH : TGT_W + 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  t_ctrl                       i_ctrl,
    input  logic signed [PW:0]          i_sum,
    output logic                        o_valid,
    input  logic                        i_ready,
    output t_ctrl                       o_ctrl,
    output logic [COMMAND_ANGLE_W-1:0]  o_command_angle
);

    localparam int UW = PW + 2;
    localparam int RW = UW - TGT_W + 1;
    localparam int MW = UW + RW;
    localparam logic [UW-1:0] BIAS_U =
        UW'(((longint'(1) << PW) + longint'(FULL_TURN) - 1) / longint'(FULL_TURN)
            * longint'(FULL_TURN));
    localparam logic [RW-1:0]    RECIP = RW'((longint'(1) << UW) / longint'(FULL_TURN));
    localparam logic [UW-1:0]    F_U   = UW'(FULL_TURN);
    localparam logic [TGT_W:0]   F_R   = (TGT_W + 1)'(FULL_TURN);

    logic                 r_b_valid;
    logic                 r_c_valid;
    logic                 r_d_valid;
    logic                 r_e_valid;
    t_ctrl                r_b_ctrl;
    t_ctrl                r_c_ctrl;
    t_ctrl                r_d_ctrl;
    t_ctrl                r_e_ctrl;
    logic [UW-1:0]        r_b_u;
    logic [UW-1:0]        r_c_u;
    logic [RW-1:0]        r_c_q;
    logic [TGT_W:0]       r_d_rem;
    logic [COMMAND_ANGLE_W-1:0] r_e_angle;

    logic                 en_b;
    logic                 en_c;
    logic                 en_d;
    logic                 en_e;
    logic [UW-1:0]        n_u;
    logic [MW-1:0]        prod;
    logic [UW-1:0]        qf;
    logic [TGT_W:0]       n_rem;
    logic [TGT_W:0]       fixed;
    logic [COMMAND_ANGLE_W-1:0] n_angle;

    assign en_e    = !r_e_valid || i_ready;
    assign en_d    = !r_d_valid || en_e;
    assign en_c    = !r_c_valid || en_d;
    assign en_b    = !r_b_valid || en_c;
    assign o_ready = en_b;

    assign n_u   = $unsigned(UW'(i_sum)) + BIAS_U;
    assign prod  = MW'(r_b_u) * MW'(RECIP);
    assign qf    = UW'(r_c_q) * F_U;
    assign n_rem = (TGT_W + 1)'(r_c_u - qf);
    assign fixed = (r_d_rem >= F_R) ? r_d_rem - F_R : r_d_rem;
    assign n_angle = (r_d_ctrl.command == CMD_SET_POSITION) ? COMMAND_ANGLE_W'(fixed) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
            r_e_valid <= 1'b0;
        end else begin
            if (en_b) begin
                r_b_valid <= i_valid;
            end
            if (en_c) begin
                r_c_valid <= r_b_valid;
            end
            if (en_d) begin
                r_d_valid <= r_c_valid;
            end
            if (en_e) begin
                r_e_valid <= r_d_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_b) begin
            r_b_ctrl <= i_ctrl;
            r_b_u    <= n_u;
        end
        if (en_c) begin
            r_c_ctrl <= r_b_ctrl;
            r_c_u    <= r_b_u;
            r_c_q    <= prod[MW-1:UW];
        end
        if (en_d) begin
            r_d_ctrl <= r_c_ctrl;
            r_d_rem  <= n_rem;
        end
        if (en_e) begin
            r_e_ctrl  <= r_d_ctrl;
            r_e_angle <= n_angle;
        end
    end

    assign o_valid         = r_e_valid;
    assign o_ctrl          = r_e_ctrl;
    assign o_command_angle = r_e_angle;

endmodule

// ===== rtl/position_setpoint_slew_limiter_unit.sv =====
// ----------------------------------------------------------------------------
// Position setpoint slew limiter unit
// Moves a commanded motor angle toward its target by a bounded step on each
// update interval and issues position or keepalive commands for one drive.
// ----------------------------------------------------------------------------
// The block takes one beat per clock cycle while its output side is not
// stalled and returns exactly one result beat for each input beat, in order.
// The angle state is updated as the beat is accepted, so ticks, target
// changes and calibrations may follow each other in consecutive cycles; the
// result passes through the core output register and the four-stage modulo
// pipeline that wraps the command angle into one full turn, whose stages hold a
// reciprocal multiply and a constant multiply. Configuration writes take effect
// on the next cycle and should be made while no beat is in flight.
module position_setpoint_slew_limiter_unit import pslu_pkg::*; #(
    parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF,
    parameter int TIMER_WIDTH = TIMER_WIDTH_DEF,
    parameter int FULL_TURN   = FULL_TURN_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [CFG_INDEX_W-1:0]      i_cfg_index,
    input  logic [CFG_DATA_W-1:0]       i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [OPERATION_W-1:0]      i_operation,
    input  logic signed [ANGLE_W-1:0]   i_angle,
    input  logic signed [ANGLE_W-1:0]   i_measured_angle,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [COMMAND_W-1:0]        o_command,
    output logic [COMMAND_ANGLE_W-1:0]  o_command_angle,
    output logic [DRIVE_W-1:0]          o_command_drive,
    output logic                        o_in_position,
    output logic                        o_error
);

    localparam int TGT_W = $clog2(FULL_TURN);
    localparam int PW    = (ANGLE_WIDTH > TGT_W) ? ANGLE_WIDTH : TGT_W + 1;

    t_cfg               r_cfg;
    logic               core_valid;
    logic               wrap_ready;
    t_ctrl              core_ctrl;
    logic signed [PW:0] core_sum;
    t_ctrl              out_ctrl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.step_interval <= STEP_INTERVAL_RST;
            r_cfg.max_step      <= MAX_STEP_RST;
            r_cfg.drive_id      <= DRIVE_ID_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_STEP_INTERVAL: r_cfg.step_interval <= i_cfg_data;
                CFG_MAX_STEP:      r_cfg.max_step      <= i_cfg_data[MAX_STEP_W-1:0];
                CFG_DRIVE_ID:      r_cfg.drive_id      <= i_cfg_data[DRIVE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    pslu_core #(
        .ANGLE_WIDTH (ANGLE_WIDTH),
        .TIMER_WIDTH (TIMER_WIDTH),
        .FULL_TURN   (FULL_TURN)
    ) u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_operation      (i_operation),
        .i_angle          (i_angle),
        .i_measured_angle (i_measured_angle),
        .i_cfg            (r_cfg),
        .o_valid          (core_valid),
        .i_ready          (wrap_ready),
        .o_ctrl           (core_ctrl),
        .o_sum            (core_sum)
    );

    pslu_wrap #(
        .ANGLE_WIDTH (ANGLE_WIDTH),
        .FULL_TURN   (FULL_TURN)
    ) u_wrap (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (core_valid),
        .o_ready         (wrap_ready),
        .i_ctrl          (core_ctrl),
        .i_sum           (core_sum),
        .o_valid         (o_out_valid),
        .i_ready         (i_out_ready),
        .o_ctrl          (out_ctrl),
        .o_command_angle (o_command_angle)
    );

    assign o_command       = out_ctrl.command;
    assign o_command_drive = out_ctrl.drive;
    assign o_in_position   = out_ctrl.in_position;
    assign o_error         = out_ctrl.error;

endmodule

// ===== rtl/pslu_checker.sv =====
// ----------------------------------------------------------------------------
// Slew limiter port checker
// Watches the result channel of the top level and checks the rules that tie
// the result fields together over time.
// ----------------------------------------------------------------------------
`include "position_setpoint_slew_limiter_unit_assert.svh"

module pslu_checker import pslu_pkg::*; #(
    parameter int FULL_TURN = FULL_TURN_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  logic [COMMAND_W-1:0]        i_command,
    input  logic [COMMAND_ANGLE_W-1:0]  i_command_angle,
    input  logic [DRIVE_W-1:0]          i_command_drive,
    input  logic                        i_in_position,
    input  logic                        i_error
);

    `PSLU_ASSERT_NXT(a_out_valid_holds, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)
    `PSLU_ASSERT_NXT(a_out_angle_holds, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable(i_command_angle))
    `PSLU_ASSERT_IMP(a_none_is_quiet, i_clk, i_rst_n, i_out_valid && (i_command == CMD_NONE), (i_command_angle == '0) && (i_command_drive == '0))
    `PSLU_ASSERT_IMP(a_error_no_command, i_clk, i_rst_n, i_out_valid && i_error, i_command == CMD_NONE)
    `PSLU_ASSERT_IMP(a_angle_wrapped, i_clk, i_rst_n, i_out_valid && (i_command == CMD_SET_POSITION), 32'(i_command_angle) < 32'(FULL_TURN))

endmodule

bind position_setpoint_slew_limiter_unit pslu_checker #(
    .FULL_TURN (FULL_TURN)
) u_pslu_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .i_command       (o_command),
    .i_command_angle (o_command_angle),
    .i_command_drive (o_command_drive),
    .i_in_position   (o_in_position),
    .i_error         (o_error)
);
